### rtl/core/qci_pkg.sv
// Package: widths, register codes, shared types and bit helpers for the quadtree cell index.
`default_nettype none
package qci_pkg;

  // Cells per side are 2**DIVIDE_LEVEL
  localparam int unsigned DIVIDE_LEVEL = 3;

  localparam int unsigned COORD_W      = 16;
  localparam int unsigned RADIUS_W     = 15;
  localparam int unsigned BOX_W        = COORD_W + 2;
  localparam int unsigned SIZE_W       = COORD_W - DIVIDE_LEVEL;
  localparam int unsigned MORTON_W     = 2 * DIVIDE_LEVEL;
  localparam int unsigned LEVEL_W      = $clog2(DIVIDE_LEVEL + 1);
  localparam int unsigned IDX_W        = MORTON_W + 1;
  localparam int unsigned NODE_INDEX_W = 7;
  localparam int unsigned NODE_LEVEL_W = 2;
  localparam int unsigned CFG_IDX_W    = 4;

  // Pipeline shape
  localparam int unsigned FRONT_ST = 2;
  localparam int unsigned DIV_ST   = DIVIDE_LEVEL + 1;
  localparam int unsigned ENC_ST   = 2;
  localparam int unsigned NUM_ST   = FRONT_ST + DIV_ST + ENC_ST;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_AREA_LEFT   = 4'd0,
    REG_AREA_TOP    = 4'd1,
    REG_AREA_RIGHT  = 4'd2,
    REG_AREA_BOTTOM = 4'd3
  } cfg_reg_e;

  localparam logic signed [COORD_W-1:0] AREA_LEFT_RST   = 16'sd0;
  localparam logic signed [COORD_W-1:0] AREA_TOP_RST    = -16'sd200;
  localparam logic signed [COORD_W-1:0] AREA_RIGHT_RST  = 16'sd1280;
  localparam logic signed [COORD_W-1:0] AREA_BOTTOM_RST = 16'sd1000;

  typedef struct packed {
    logic signed [COORD_W-1:0] left;
    logic signed [COORD_W-1:0] top;
    logic signed [COORD_W-1:0] right;
    logic signed [COORD_W-1:0] bottom;
  } area_t;

  // Front end result: outside flag, corner offsets into the area, cell sizes
  typedef struct packed {
    logic               outside;
    logic [COORD_W-1:0] off_l;
    logic [COORD_W-1:0] off_t;
    logic [COORD_W-1:0] off_r;
    logic [COORD_W-1:0] off_b;
    logic [SIZE_W-1:0]  size_w;
    logic [SIZE_W-1:0]  size_h;
  } front_t;

  // x into even bits, y into odd bits
  function automatic logic [MORTON_W-1:0] interleave(input logic [DIVIDE_LEVEL-1:0] x,
                                                     input logic [DIVIDE_LEVEL-1:0] y);
    logic [MORTON_W-1:0] m;
    m = '0;
    for (int i = 0; i < DIVIDE_LEVEL; i++) begin
      m[2*i]   = x[i];
      m[2*i+1] = y[i];
    end
    return m;
  endfunction

  // (4**lvl - 1) / 3 is lvl ones on the even bit positions
  function automatic logic [IDX_W-1:0] level_base(input logic [LEVEL_W-1:0] lvl);
    logic [IDX_W-1:0] b;
    b = '0;
    for (int j = 0; j < DIVIDE_LEVEL; j++) begin
      if (LEVEL_W'(j) < lvl) begin
        b[2*j] = 1'b1;
      end
    end
    return b;
  endfunction

endpackage
`default_nettype wire

### rtl/core/qci_if.sv
// Interfaces: item, result and configuration write channels.
`default_nettype none
interface qci_item_if;
  logic                                 valid;
  logic                                 ready;
  logic signed [qci_pkg::COORD_W-1:0]   center_x;
  logic signed [qci_pkg::COORD_W-1:0]   center_y;
  logic        [qci_pkg::RADIUS_W-1:0]  radius;

  modport source (output valid, output center_x, output center_y, output radius,
                  input ready);
  modport sink   (input valid, input center_x, input center_y, input radius,
                  output ready);
endinterface

interface qci_result_if;
  logic                                  valid;
  logic                                  ready;
  logic                                  outside;
  logic [qci_pkg::NODE_INDEX_W-1:0]      node_index;
  logic [qci_pkg::NODE_LEVEL_W-1:0]      node_level;

  modport source (output valid, output outside, output node_index, output node_level,
                  input ready);
  modport sink   (input valid, input outside, input node_index, input node_level,
                  output ready);
endinterface

interface qci_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [qci_pkg::CFG_IDX_W-1:0]     index;
  logic [qci_pkg::COORD_W-1:0]       data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### rtl/core/qci_front.sv
// Front end: bounding box, cell sizes, area check and corner offsets over two stages.
`default_nettype none
module qci_front (
  input  wire logic                                  clk_i,
  input  wire logic [qci_pkg::FRONT_ST-1:0]          en_i,
  input  wire logic signed [qci_pkg::COORD_W-1:0]    center_x_i,
  input  wire logic signed [qci_pkg::COORD_W-1:0]    center_y_i,
  input  wire logic        [qci_pkg::RADIUS_W-1:0]   radius_i,
  input  wire qci_pkg::area_t                        area_i,
  output qci_pkg::front_t                            front_o
);

  localparam int unsigned BW = qci_pkg::BOX_W;
  localparam int unsigned DW = qci_pkg::COORD_W + 1;
  localparam int unsigned CW = qci_pkg::COORD_W;
  localparam int unsigned L  = qci_pkg::DIVIDE_LEVEL;

  logic signed [BW-1:0] cx_e, cy_e, r_e;
  logic signed [DW-1:0] span_w, span_h;
  logic signed [BW-1:0] bl_q, bt_q, br_q, bb_q;
  logic                 zero_q;
  logic [qci_pkg::SIZE_W-1:0] size_w_q, size_h_q;
  logic signed [BW-1:0] left_e, top_e, right_e, bottom_e;
  qci_pkg::front_t      front_d, front_q;

  // stage A: box edges and cell sizes
  always_comb begin
    cx_e   = BW'(center_x_i);
    cy_e   = BW'(center_y_i);
    r_e    = BW'(radius_i);
    span_w = DW'(area_i.right) - DW'(area_i.left);
    span_h = DW'(area_i.bottom) - DW'(area_i.top);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      bl_q     <= cx_e - r_e;
      bt_q     <= cy_e - r_e;
      br_q     <= cx_e + r_e;
      bb_q     <= cy_e + r_e;
      // cell size below one pixel, or a reversed area
      zero_q   <= span_w[CW] || (span_w[CW-1:L] == '0) ||
                  span_h[CW] || (span_h[CW-1:L] == '0);
      size_w_q <= span_w[CW-1:L];
      size_h_q <= span_h[CW-1:L];
    end
  end

  // stage B: area check and offsets (area edges count as inside)
  always_comb begin
    left_e   = BW'(area_i.left);
    top_e    = BW'(area_i.top);
    right_e  = BW'(area_i.right);
    bottom_e = BW'(area_i.bottom);
    front_d.outside = zero_q || (bl_q < left_e) || (bt_q < top_e) ||
                      (br_q > right_e) || (bb_q > bottom_e);
    front_d.off_l  = CW'(bl_q - left_e);
    front_d.off_t  = CW'(bt_q - top_e);
    front_d.off_r  = CW'(br_q - left_e);
    front_d.off_b  = CW'(bb_q - top_e);
    front_d.size_w = size_w_q;
    front_d.size_h = size_h_q;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      front_q <= front_d;
    end
  end

  assign front_o = front_q;

endmodule
`default_nettype wire

### rtl/core/qci_div_lane.sv
// Divider lane: saturating cell quotient, a saturation check and then one compare-subtract per stage.
`default_nettype none
module qci_div_lane (
  input  wire logic                                clk_i,
  input  wire logic [qci_pkg::DIV_ST-1:0]          en_i,
  input  wire logic [qci_pkg::COORD_W-1:0]         num_i,
  input  wire logic [qci_pkg::SIZE_W-1:0]          size_i,
  output logic      [qci_pkg::DIVIDE_LEVEL-1:0]    quot_o
);

  localparam int unsigned L  = qci_pkg::DIVIDE_LEVEL;
  localparam int unsigned CW = qci_pkg::COORD_W;

  // remainder and divisor are needed only up to the last quotient step
  logic [CW-1:0]              rem_q  [L];
  logic [qci_pkg::SIZE_W-1:0] size_q [L];
  logic [L-1:0]               quot_q [L+1];
  logic                       sat_q  [L+1];

  logic [CW-1:0] full_div;

  // first stage: quotient reaches the cell count, saturate
  assign full_div = CW'(size_i) << L;

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      rem_q[0]  <= num_i;
      size_q[0] <= size_i;
      quot_q[0] <= '0;
      sat_q[0]  <= (num_i >= full_div);
    end
  end

  for (genvar s = 1; s <= L; s++) begin : g_step
    localparam int unsigned K = L - s;
    logic [CW-1:0] trial;
    logic          ge;

    assign trial = CW'(size_q[s-1]) << K;
    assign ge    = rem_q[s-1] >= trial;

    // bits from K down are still clear, so the new bit is ORed in
    always_ff @(posedge clk_i) begin
      if (en_i[s]) begin
        quot_q[s] <= quot_q[s-1] | (L'(ge) << K);
        sat_q[s]  <= sat_q[s-1];
      end
    end

    if (s < L) begin : g_carry
      always_ff @(posedge clk_i) begin
        if (en_i[s]) begin
          rem_q[s]  <= ge ? (rem_q[s-1] - trial) : rem_q[s-1];
          size_q[s] <= size_q[s-1];
        end
      end
    end
  end

  assign quot_o = sat_q[L] ? '1 : quot_q[L];

endmodule
`default_nettype wire

### rtl/core/qci_encode.sv
// Encoder: Morton codes, containing level, node index and the output register.
`default_nettype none
module qci_encode (
  input  wire logic                                 clk_i,
  input  wire logic [qci_pkg::ENC_ST-1:0]           en_i,
  input  wire logic                                 outside_i,
  input  wire logic [qci_pkg::DIVIDE_LEVEL-1:0]     qx0_i,
  input  wire logic [qci_pkg::DIVIDE_LEVEL-1:0]     qy0_i,
  input  wire logic [qci_pkg::DIVIDE_LEVEL-1:0]     qx1_i,
  input  wire logic [qci_pkg::DIVIDE_LEVEL-1:0]     qy1_i,
  output logic                                      outside_o,
  output logic [qci_pkg::NODE_INDEX_W-1:0]          node_index_o,
  output logic [qci_pkg::NODE_LEVEL_W-1:0]          node_level_o
);

  localparam int unsigned L  = qci_pkg::DIVIDE_LEVEL;
  localparam int unsigned LW = qci_pkg::LEVEL_W;
  localparam int unsigned MW = qci_pkg::MORTON_W;
  localparam int unsigned IW = qci_pkg::IDX_W;

  logic [MW-1:0] m0, m1, diff;
  logic [LW-1:0] lvl_d;
  logic [MW-1:0] m0_q;
  logic [LW-1:0] lvl_q;
  logic          out1_q;
  logic [LW:0]   shamt;
  logic [IW-1:0] idx;

  // E1: highest differing pair sets the depth
  always_comb begin
    m0    = qci_pkg::interleave(qx0_i, qy0_i);
    m1    = qci_pkg::interleave(qx1_i, qy1_i);
    diff  = m0 ^ m1;
    lvl_d = LW'(L);
    for (int i = 0; i < L; i++) begin
      if (diff[2*i +: 2] != 2'b00) begin
        lvl_d = LW'(L - 1 - i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      m0_q   <= m0;
      lvl_q  <= lvl_d;
      out1_q <= outside_i;
    end
  end

  // E2: level base plus code shifted to that level
  always_comb begin
    shamt = {LW'(L) - lvl_q, 1'b0};
    idx   = qci_pkg::level_base(lvl_q) + IW'(m0_q >> shamt);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      outside_o    <= out1_q;
      node_index_o <= out1_q ? '0 : qci_pkg::NODE_INDEX_W'(idx);
      node_level_o <= out1_q ? '0 : qci_pkg::NODE_LEVEL_W'(lvl_q);
    end
  end

endmodule
`default_nettype wire

### rtl/core/quadtree_cell_index_core.sv
// Top level: linear quadtree cell index pipeline with area configuration.
//
//  channel   modport  carries                          accepted when
//  item_i    sink     center_x, center_y, radius       valid && ready
//  result_o  source   outside, node_index, node_level  valid && ready
//  cfg_i     sink     index, data (area edge)          valid && ready
//
// One item per cycle sustained while result_o stays ready; the pipeline has
// two front-end stages, DIVIDE_LEVEL + 1 quotient stages (a saturation check,
// then one compare-subtract per quotient bit) and two encoder stages.
// Each stage holds while the one after it is full and stalled, so bubbles
// close up and the input keeps taking items into empty stages while a result waits.
// Reset clears the stage valid bits and loads the default area.
// Configuration is always ready; a write to an unknown index is dropped.
`default_nettype none
module quadtree_cell_index_core (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  qci_item_if.sink           item_i,
  qci_result_if.source       result_o,
  qci_cfg_if.sink            cfg_i
);

  localparam int unsigned N  = qci_pkg::NUM_ST;
  localparam int unsigned FS = qci_pkg::FRONT_ST;
  localparam int unsigned DS = qci_pkg::DIV_ST;
  localparam int unsigned ES = qci_pkg::ENC_ST;
  localparam int unsigned L  = qci_pkg::DIVIDE_LEVEL;

  qci_pkg::area_t  area_q;
  qci_pkg::front_t front;

  logic [N-1:0] v_q;
  logic [N-1:0] take;
  logic         out_div_q [DS];

  logic [L-1:0] qx0, qy0, qx1, qy1;

  // ---------------------------------------------------------------------------
  // configuration registers
  // ---------------------------------------------------------------------------
  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area_q.left   <= qci_pkg::AREA_LEFT_RST;
      area_q.top    <= qci_pkg::AREA_TOP_RST;
      area_q.right  <= qci_pkg::AREA_RIGHT_RST;
      area_q.bottom <= qci_pkg::AREA_BOTTOM_RST;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.index)
        qci_pkg::REG_AREA_LEFT:   area_q.left   <= cfg_i.data;
        qci_pkg::REG_AREA_TOP:    area_q.top    <= cfg_i.data;
        qci_pkg::REG_AREA_RIGHT:  area_q.right  <= cfg_i.data;
        qci_pkg::REG_AREA_BOTTOM: area_q.bottom <= cfg_i.data;
        default: ;
      endcase
    end
  end

  // ---------------------------------------------------------------------------
  // stage control: a stage loads when empty or when its item moves on
  // ---------------------------------------------------------------------------
  always_comb begin
    take[N-1] = !v_q[N-1] || result_o.ready;
    for (int k = N - 2; k >= 0; k--) begin
      take[k] = !v_q[k] || take[k+1];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else begin
      if (take[0]) begin
        v_q[0] <= item_i.valid;
      end
      for (int k = 1; k < N; k++) begin
        if (take[k]) begin
          v_q[k] <= v_q[k-1];
        end
      end
    end
  end

  assign item_i.ready   = take[0];
  assign result_o.valid = v_q[N-1];

  // ---------------------------------------------------------------------------
  // datapath
  // ---------------------------------------------------------------------------
  qci_front u_front (
    .clk_i      (clk_i),
    .en_i       (take[FS-1:0]),
    .center_x_i (item_i.center_x),
    .center_y_i (item_i.center_y),
    .radius_i   (item_i.radius),
    .area_i     (area_q),
    .front_o    (front)
  );

  // outside flag rides alongside the quotient lanes
  always_ff @(posedge clk_i) begin
    for (int j = 0; j < DS; j++) begin
      if (take[FS+j]) begin
        out_div_q[j] <= (j == 0) ? front.outside : out_div_q[(j == 0) ? 0 : j-1];
      end
    end
  end

  // four lanes: top-left x/y, bottom-right x/y
  qci_div_lane u_lane_x0 (
    .clk_i  (clk_i),
    .en_i   (take[FS +: DS]),
    .num_i  (front.off_l),
    .size_i (front.size_w),
    .quot_o (qx0)
  );

  qci_div_lane u_lane_y0 (
    .clk_i  (clk_i),
    .en_i   (take[FS +: DS]),
    .num_i  (front.off_t),
    .size_i (front.size_h),
    .quot_o (qy0)
  );

  qci_div_lane u_lane_x1 (
    .clk_i  (clk_i),
    .en_i   (take[FS +: DS]),
    .num_i  (front.off_r),
    .size_i (front.size_w),
    .quot_o (qx1)
  );

  qci_div_lane u_lane_y1 (
    .clk_i  (clk_i),
    .en_i   (take[FS +: DS]),
    .num_i  (front.off_b),
    .size_i (front.size_h),
    .quot_o (qy1)
  );

  // last encoder stage is the output register
  qci_encode u_encode (
    .clk_i        (clk_i),
    .en_i         (take[FS+DS +: ES]),
    .outside_i    (out_div_q[DS-1]),
    .qx0_i        (qx0),
    .qy0_i        (qy0),
    .qx1_i        (qx1),
    .qy1_i        (qy1),
    .outside_o    (result_o.outside),
    .node_index_o (result_o.node_index),
    .node_level_o (result_o.node_level)
  );

  // ---------------------------------------------------------------------------
  // assertions
  // ---------------------------------------------------------------------------
  a_empty_out_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_o.valid |-> item_i.ready)
    else $error("input stalled with an empty output register");

  a_accept_enters: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (item_i.valid && item_i.ready) |=> v_q[0])
    else $error("accepted item missing from first stage");

  a_outside_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_o.valid && result_o.outside) |->
      (result_o.node_index == '0) && (result_o.node_level == '0))
    else $error("outside result carries a node");

endmodule
`default_nettype wire

### sim/qci_node_checker.sv
// Checker: watches the channels, predicts the containing quadtree node and compares results.
`timescale 1ns / 1ps
module qci_node_checker (
  input  logic                                    clk_i,
  input  logic                                    rst_ni,
  input  logic                                    item_valid_i,
  input  logic                                    item_ready_i,
  input  logic signed [qci_pkg::COORD_W-1:0]      center_x_i,
  input  logic signed [qci_pkg::COORD_W-1:0]      center_y_i,
  input  logic        [qci_pkg::RADIUS_W-1:0]     radius_i,
  input  logic                                    res_valid_i,
  input  logic                                    res_ready_i,
  input  logic                                    outside_i,
  input  logic        [qci_pkg::NODE_INDEX_W-1:0] node_index_i,
  input  logic        [qci_pkg::NODE_LEVEL_W-1:0] node_level_i,
  input  logic                                    cfg_valid_i,
  input  logic                                    cfg_ready_i,
  input  logic        [qci_pkg::CFG_IDX_W-1:0]    cfg_index_i,
  input  logic        [qci_pkg::COORD_W-1:0]      cfg_data_i,
  output int                                      mismatches_o,
  output int                                      waiting_o,
  output int                                      checked_o,
  output int                                      outside_o,
  output logic        [3:0]                       levels_seen_o
);

  localparam int LVL   = qci_pkg::DIVIDE_LEVEL;
  localparam int CELLS = 1 << LVL;

  typedef struct packed {
    logic                             outside;
    logic [qci_pkg::NODE_INDEX_W-1:0] node_index;
    logic [qci_pkg::NODE_LEVEL_W-1:0] node_level;
  } node_t;

  typedef struct packed {
    logic signed [qci_pkg::COORD_W-1:0] cx;
    logic signed [qci_pkg::COORD_W-1:0] cy;
    logic [qci_pkg::RADIUS_W-1:0]       r;
    node_t                              node;
  } open_query_t;

  qci_pkg::area_t area;
  open_query_t    open_queries[$];
  open_query_t    oldest;
  node_t          got;

  // Low 16 bits spread onto the even bit positions
  function automatic logic [31:0] spread(input logic [31:0] v);
    logic [31:0] n;
    n = v & 32'h0000_ffff;
    n = (n | (n << 8)) & 32'h00ff_00ff;
    n = (n | (n << 4)) & 32'h0f0f_0f0f;
    n = (n | (n << 2)) & 32'h3333_3333;
    n = (n | (n << 1)) & 32'h5555_5555;
    return n;
  endfunction

  // Cell along one axis; the far edge and the division remainder clamp to the last cell
  function automatic int cell_along(input int offset, input int size);
    int c;
    c = offset / size;
    return (c > CELLS - 1) ? CELLS - 1 : c;
  endfunction

  function automatic node_t locate_node(input qci_pkg::area_t a,
                                        input logic signed [qci_pkg::COORD_W-1:0] cx,
                                        input logic signed [qci_pkg::COORD_W-1:0] cy,
                                        input logic [qci_pkg::RADIUS_W-1:0] r);
    int          x0, y0, x1, y1, cw, ch, depth;
    logic [31:0] m0, m1, diff, base;
    node_t       n;
    n = '{outside: 1'b1, node_index: '0, node_level: '0};
    x0 = int'(cx) - int'(r);
    y0 = int'(cy) - int'(r);
    x1 = int'(cx) + int'(r);
    y1 = int'(cy) + int'(r);
    if (x0 < int'(a.left) || y0 < int'(a.top) || x1 > int'(a.right) || y1 > int'(a.bottom))
      return n;
    cw = (int'(a.right) - int'(a.left)) / CELLS;
    ch = (int'(a.bottom) - int'(a.top)) / CELLS;
    if (cw <= 0 || ch <= 0)
      return n;
    m0 = spread(32'(cell_along(x0 - int'(a.left), cw)))
       | (spread(32'(cell_along(y0 - int'(a.top), ch))) << 1);
    m1 = spread(32'(cell_along(x1 - int'(a.left), cw)))
       | (spread(32'(cell_along(y1 - int'(a.top), ch))) << 1);
    diff = m0 ^ m1;
    // highest differing pair wins, so scan upwards and overwrite
    depth = LVL;
    for (int i = 0; i < LVL; i++) begin
      if (((diff >> (2 * i)) & 32'd3) != 0)
        depth = LVL - 1 - i;
    end
    base = ((32'd1 << (2 * depth)) - 32'd1) / 32'd3;
    n.outside    = 1'b0;
    n.node_index = qci_pkg::NODE_INDEX_W'(base + (m0 >> (2 * (LVL - depth))));
    n.node_level = qci_pkg::NODE_LEVEL_W'(depth);
    return n;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      area.left   = qci_pkg::AREA_LEFT_RST;
      area.top    = qci_pkg::AREA_TOP_RST;
      area.right  = qci_pkg::AREA_RIGHT_RST;
      area.bottom = qci_pkg::AREA_BOTTOM_RST;
      open_queries.delete();
      mismatches_o  = 0;
      waiting_o     = 0;
      checked_o     = 0;
      outside_o     = 0;
      levels_seen_o = '0;
    end else begin
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          qci_pkg::REG_AREA_LEFT:   area.left   = cfg_data_i;
          qci_pkg::REG_AREA_TOP:    area.top    = cfg_data_i;
          qci_pkg::REG_AREA_RIGHT:  area.right  = cfg_data_i;
          qci_pkg::REG_AREA_BOTTOM: area.bottom = cfg_data_i;
          default: ;
        endcase
      end
      if (item_valid_i && item_ready_i) begin
        oldest.cx   = center_x_i;
        oldest.cy   = center_y_i;
        oldest.r    = radius_i;
        oldest.node = locate_node(area, center_x_i, center_y_i, radius_i);
        open_queries.insert(open_queries.size(), oldest);
      end
      if (res_valid_i && res_ready_i) begin
        got = '{outside: outside_i, node_index: node_index_i, node_level: node_level_i};
        if (open_queries.size() == 0) begin
          mismatches_o++;
          if (mismatches_o <= 10)
            $display("[%0t] unexpected result: outside=%0d index=%0d level=%0d",
                     $time, got.outside, got.node_index, got.node_level);
        end else begin
          oldest = open_queries.pop_front();
          checked_o++;
          if (got.outside)
            outside_o++;
          else
            levels_seen_o[got.node_level] = 1'b1;
          if (got !== oldest.node) begin
            mismatches_o++;
            if (mismatches_o <= 10)
              $display({"[%0t] mismatch for x=%0d y=%0d r=%0d: ",
                        "expected %0d/%0d/%0d, got %0d/%0d/%0d"},
                       $time, oldest.cx, oldest.cy, oldest.r,
                       oldest.node.outside, oldest.node.node_index, oldest.node.node_level,
                       got.outside, got.node_index, got.node_level);
          end
        end
      end
      waiting_o = open_queries.size();
    end
  end

endmodule

### sim/quadtree_cell_index_core_tb.sv
// Testbench top: stimulus, idling and verdict for the quadtree cell index core.
`timescale 1ns / 1ps
module quadtree_cell_index_core_tb;

  // Pipeline is DIVIDE_LEVEL + 5 deep; this idle wait comes before touching config or ending
  localparam int DRAIN_CYCLES = 2 * (qci_pkg::DIVIDE_LEVEL + 5);
  // Timeout in ns at a 10 ns clock
  localparam int LIMIT_NS     = 10_000_000;

  logic clk;
  logic rst_n;

  qci_item_if   item_ch ();
  qci_result_if result_ch ();
  qci_cfg_if    cfg_ch ();

  int         mismatches;
  int         waiting;
  int         checked;
  int         outside_n;
  logic [3:0] levels_seen;

  // Area as last written; steers where the random circles land
  qci_pkg::area_t cur_area;
  int             settings_used;
  // When set, neither side idles: back-to-back items and a ready that never drops
  bit             calm;

  quadtree_cell_index_core DUT (
    .clk_i    (clk),
    .rst_ni   (rst_n),
    .item_i   (item_ch),
    .result_o (result_ch),
    .cfg_i    (cfg_ch)
  );

  qci_node_checker u_index_chk (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .item_valid_i  (item_ch.valid),
    .item_ready_i  (item_ch.ready),
    .center_x_i    (item_ch.center_x),
    .center_y_i    (item_ch.center_y),
    .radius_i      (item_ch.radius),
    .res_valid_i   (result_ch.valid),
    .res_ready_i   (result_ch.ready),
    .outside_i     (result_ch.outside),
    .node_index_i  (result_ch.node_index),
    .node_level_i  (result_ch.node_level),
    .cfg_valid_i   (cfg_ch.valid),
    .cfg_ready_i   (cfg_ch.ready),
    .cfg_index_i   (cfg_ch.index),
    .cfg_data_i    (cfg_ch.data),
    .mismatches_o  (mismatches),
    .waiting_o     (waiting),
    .checked_o     (checked),
    .outside_o     (outside_n),
    .levels_seen_o (levels_seen)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(LIMIT_NS);
    $display("Run timed out with %0d results still outstanding", waiting);
    $display("RESULT: ERROR");
    $finish;
  end

  // Idle length: mostly short, now and then a long hole
  function automatic int idle_len();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 70) return $urandom_range(1, 3);
    if (pick < 93) return $urandom_range(4, 10);
    return $urandom_range(20, 60);
  endfunction

  function automatic int item_gap();
    if (calm || $urandom_range(0, 99) < 50) return 0;
    return idle_len();
  endfunction

  // Result side: ready in bursts with stalls between, solid high in calm stretches
  initial begin
    int hold;
    result_ch.ready = 1'b0;
    @(negedge clk);
    forever begin
      result_ch.ready = 1'b1;
      hold = calm ? 50 : $urandom_range(1, 12);
      repeat (hold) @(negedge clk);
      if (!calm) begin
        result_ch.ready = 1'b0;
        repeat (idle_len()) @(negedge clk);
      end
    end
  end

  // Presents one item at the falling edge and holds it until taken. Valid stays high
  // into the next item unless a gap is drawn.
  task automatic send(input int x, input int y, input int r);
    int gap;
    item_ch.center_x = 16'(x);
    item_ch.center_y = 16'(y);
    item_ch.radius   = 15'(r);
    item_ch.valid    = 1'b1;
    do @(posedge clk); while (!item_ch.ready);
    @(negedge clk);
    gap = item_gap();
    if (gap > 0) begin
      item_ch.valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
  endtask

  // Leaves valid high; the caller drops it after the last write of a batch
  task automatic write_reg(input logic [qci_pkg::CFG_IDX_W-1:0] idx,
                           input logic [qci_pkg::COORD_W-1:0] value);
    cfg_ch.index = idx;
    cfg_ch.data  = value;
    cfg_ch.valid = 1'b1;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  // Block goes idle: no item offered, every result back, then a further idle wait
  task automatic drain();
    item_ch.valid = 1'b0;
    while (waiting != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // New area, written only once idle; one stray write to an unmapped index rides along
  task automatic apply_area(input int l, input int t, input int r, input int b,
                            input logic [qci_pkg::CFG_IDX_W-1:0] spare_idx);
    drain();
    write_reg(qci_pkg::REG_AREA_LEFT, 16'(l));
    write_reg(qci_pkg::REG_AREA_TOP, 16'(t));
    write_reg(qci_pkg::REG_AREA_RIGHT, 16'(r));
    write_reg(qci_pkg::REG_AREA_BOTTOM, 16'(b));
    write_reg(spare_idx, 16'($urandom));
    cfg_ch.valid    = 1'b0;
    cur_area.left   = 16'(l);
    cur_area.top    = 16'(t);
    cur_area.right  = 16'(r);
    cur_area.bottom = 16'(b);
    settings_used++;
  endtask

  task automatic random_area(input logic [qci_pkg::CFG_IDX_W-1:0] spare_idx);
    int w, h, l, t;
    w = int'($urandom_range(8, 20000));
    h = int'($urandom_range(8, 20000));
    l = int'($urandom_range(0, 65535 - w)) - 32768;
    t = int'($urandom_range(0, 65535 - h)) - 32768;
    apply_area(l, t, l + w, t + h, spare_idx);
  endtask

  // Mostly circles that sit inside the area, with radii skewed small so that every
  // depth turns up; a share pinned on an area edge or one pixel past it; the rest raw noise.
  function automatic void make_query(output int x, output int y, output int r);
    int w, h, maxr, kind, sel, off;
    w    = int'(cur_area.right) - int'(cur_area.left);
    h    = int'(cur_area.bottom) - int'(cur_area.top);
    kind = int'($urandom_range(0, 99));
    if (w >= 0 && h >= 0 && kind < 85) begin
      maxr = ((w < h) ? w : h) / 2;
      sel  = int'($urandom_range(0, 9));
      if (sel < 5)      r = int'($urandom_range(0, maxr / 16));
      else if (sel < 8) r = int'($urandom_range(0, maxr / 4));
      else              r = int'($urandom_range(0, maxr));
      x = int'(cur_area.left) + r + int'($urandom_range(0, w - 2 * r));
      y = int'(cur_area.top) + r + int'($urandom_range(0, h - 2 * r));
      if (kind >= 65) begin
        off = int'($urandom_range(0, 1));
        case ($urandom_range(0, 3))
          0:       x = int'(cur_area.left) + r - off;
          1:       x = int'(cur_area.right) - r + off;
          2:       y = int'(cur_area.top) + r - off;
          default: y = int'(cur_area.bottom) - r + off;
        endcase
      end
    end else begin
      x = int'($urandom_range(0, 65535)) - 32768;
      y = int'($urandom_range(0, 65535)) - 32768;
      r = kind[0] ? int'($urandom_range(0, 32767)) : int'($urandom_range(0, 64));
    end
  endfunction

  task automatic random_items(input int count);
    int x, y, r;
    repeat (count) begin
      make_query(x, y, r);
      send(x, y, r);
    end
  endtask

  initial begin
    rst_n            = 1'b0;
    item_ch.valid    = 1'b0;
    item_ch.center_x = '0;
    item_ch.center_y = '0;
    item_ch.radius   = '0;
    cfg_ch.valid     = 1'b0;
    cfg_ch.index     = '0;
    cfg_ch.data      = '0;
    cur_area.left    = qci_pkg::AREA_LEFT_RST;
    cur_area.top     = qci_pkg::AREA_TOP_RST;
    cur_area.right   = qci_pkg::AREA_RIGHT_RST;
    cur_area.bottom  = qci_pkg::AREA_BOTTOM_RST;
    settings_used    = 1;
    calm             = 1'b0;
    repeat (6) @(negedge clk);
    rst_n = 1'b1;
    @(negedge clk);

    // Reset area: 160 x 150 pixel cells
    send(640, 400, 300);           // spans the middle, root node
    send(10, -190, 0);             // single point, deepest level, first cell
    send(640, 400, 0);             // deepest level mid-area
    send(80, -125, 75);            // two cells tall, one level up
    send(320, 100, 150);           // spans two cells wide and three tall
    send(1280, 1000, 0);           // far corner: cell index clamps to the last cell
    send(5, -195, 5);              // box edges on the left and top area edges
    send(1275, 995, 5);            // box edges on the right and bottom area edges
    send(0, 0, 1);                 // one pixel past the left edge
    send(1280, 0, 1);              // one past the right edge
    send(100, -200, 1);            // one past the top edge
    send(100, 1000, 1);            // one past the bottom edge
    send(-32768, -32768, 0);       // field extremes, all outside here
    send(32767, 32767, 32767);
    send(-1, 0, 32767);
    random_items(150);

    // Full coordinate range, no idling on either side
    calm = 1'b1;
    apply_area(-32768, -32768, 32767, 32767, 4'd4);
    send(-32768, -32768, 0);
    send(32767, 32767, 0);         // remainder of the division pushes past the last cell
    send(0, 0, 32767);             // largest radius that still fits
    send(-1, -1, 32767);
    send(32767, -32768, 0);
    send(0, 0, 16383);
    random_items(200);

    // Smallest usable area: one pixel per cell
    calm = 1'b0;
    apply_area(0, 0, 8, 8, 4'd5);
    send(8, 8, 0);
    send(4, 4, 4);
    send(7, 7, 0);
    random_items(150);

    // Sizes that leave a remainder; cells one pixel high
    apply_area(-100, 50, 1000, 61, 4'd6);
    random_items(150);

    // Width below one pixel per cell: every query reports outside
    apply_area(10, 10, 17, 500, 4'd8);
    send(13, 100, 0);
    send(10, 10, 0);
    random_items(50);

    // Edges crossed over: nothing can be inside
    apply_area(1000, 1000, -1000, -1000, 4'd9);
    random_items(40);

    for (int k = 0; k < 3; k++) begin
      calm = (k == 1);
      random_area(4'(10 + k));
      random_items(170);
    end

    // Back to the reset area, written explicitly, top unmapped index as the stray write
    calm = 1'b0;
    apply_area(int'(qci_pkg::AREA_LEFT_RST), int'(qci_pkg::AREA_TOP_RST),
               int'(qci_pkg::AREA_RIGHT_RST), int'(qci_pkg::AREA_BOTTOM_RST), 4'd15);
    random_items(200);

    drain();
    $display("Checked %0d results across %0d area settings; %0d outside, node levels seen %b.",
             checked, settings_used, outside_n, levels_seen);
    if (waiting != 0)
      $display("%0d expected results never arrived", waiting);
    if (mismatches == 0 && waiting == 0)
      $display("RESULT: OK");
    else
      $display("RESULT: ERROR");
    $finish;
  end

endmodule
